### rtl/core/smx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Softmax package
// Shared constants, types and the fractional power table of the softmax engine.
// ----------------------------------------------------------------------------
package smx_pkg;

	localparam int unsigned DEPTH_DEF       = 64;
	localparam int unsigned VALUE_WIDTH_DEF = 16;
	localparam int unsigned PROB_W          = 16;
	localparam int unsigned POS_W           = 6;
	localparam int unsigned SUM_W           = 23;
	localparam int unsigned DIV_W           = 32;
	localparam logic [14:0] LOG2E_Q14       = 15'd23637;

	// Controller states.
	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_SUM,
		ST_DIV,
		ST_NORM,
		ST_CLEAR
	} smx_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;      // return vector state to reset values
		logic rd_start;   // restart read index
		logic sum_en;     // exponent pass running
		logic div_start;  // start the reciprocal divider
		logic norm_en;    // normalise pass running
	} smx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sum_done;
		logic div_done;
		logic norm_done;
	} smx_stat_t;

	// 2^(-2^(b-8)) in Q0.16, indexed by fraction bit.
	function automatic logic [15:0] frac_pow(input logic [2:0] b);
		logic [15:0] r;
		begin
			case (b)
				3'd0: r = 16'd65359;
				3'd1: r = 16'd65182;
				3'd2: r = 16'd64830;
				3'd3: r = 16'd64132;
				3'd4: r = 16'd62757;
				3'd5: r = 16'd60097;
				3'd6: r = 16'd55109;
				default: r = 16'd46341;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

### rtl/core/smx_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                          clk,
	input  wire logic                                          wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                              wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

### rtl/core/smx_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Exponent unit
// Pipelined exp(x - max) in Q0.16: one multiply and one table step per fraction stage.
// ----------------------------------------------------------------------------
module smx_exp
	import smx_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic [VALUE_WIDTH-1:0] x,
	input  wire logic [VALUE_WIDTH-1:0] mx,
	output logic                        out_valid,
	output logic [15:0]                 e
);

	localparam int unsigned DW = VALUE_WIDTH + 1;
	localparam int unsigned TW = DW + 15 - 14 + 1;

	logic [10:0]   v_q;
	logic [TW-1:0] t_s1;
	logic [16:0]   acc_q [9];
	logic [7:0]    f_q [9];
	logic [TW-9:0] n_q [9];
	logic [DW-1:0] d;
	logic [DW+15:0] prod;

	// Distance to the maximum, always non-negative.
	assign d    = {mx[VALUE_WIDTH-1], mx} - {x[VALUE_WIDTH-1], x};
	assign prod = (DW+16)'(d) * (DW+16)'(LOG2E_Q14) + (DW+16)'(8192);

	// Valid bits follow each item through the eleven stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[9:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= TW'(prod >> 14);
	end

	// Split into integer and fraction, start accumulator.
	always_ff @(posedge clk) begin
		acc_q[0] <= 17'd65536;
		f_q[0]   <= t_s1[7:0];
		n_q[0]   <= t_s1[TW-1:8];
	end

	// One fraction bit per stage, from bit 7 down.
	for (genvar g = 0; g < 8; g++) begin : g_frac
		logic [32:0] m;
		assign m = 33'(acc_q[g]) * 33'(frac_pow(3'(7 - g))) + 33'd32768;
		always_ff @(posedge clk) begin
			f_q[g+1]   <= f_q[g];
			n_q[g+1]   <= n_q[g];
			acc_q[g+1] <= f_q[g][7-g] ? 17'(m >> 16) : acc_q[g];
		end
	end

	// Integer shift and clamp.
	logic [16:0] sh;
	assign sh = (n_q[8] > (TW-8)'(16)) ? 17'd0 : (acc_q[8] >> n_q[8]);
	always_ff @(posedge clk) begin
		e <= sh[16] ? 16'hFFFF : sh[15:0];
	end
	assign out_valid = v_q[10];

endmodule
`default_nettype wire

### rtl/core/smx_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reciprocal divider
// Restoring division of 65535 * 65536 by the exponent sum, one bit a cycle.
// ----------------------------------------------------------------------------
module smx_div
	import smx_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] den,
	output logic                  done,
	output logic [DIV_W-1:0]      quo
);

	logic [DIV_W-1:0] num_q;
	logic [SUM_W:0]   rem_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [SUM_W:0]   trial;

	assign trial = {rem_q[SUM_W-1:0], num_q[DIV_W-1]};

	// Shift one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= 32'hFFFF_0000;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= trial - {1'b0, den};
				num_q <= {num_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[DIV_W-2:0], 1'b0};
			end
		end
	end
	assign quo = num_q;

endmodule
`default_nettype wire

### rtl/core/smx_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Softmax datapath
// Element store, running maximum, exponent passes, sum and normalisation.
// ----------------------------------------------------------------------------
module smx_datapath
	import smx_pkg::*;
#(
	parameter int unsigned DEPTH       = DEPTH_DEF,
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire smx_cmd_t               cmd,
	output smx_stat_t                   stat,
	input  wire logic                   in_xfer,
	input  wire logic [VALUE_WIDTH-1:0] in_value,
	input  wire logic                   out_busy,
	output logic                        res_valid,
	output logic [PROB_W-1:0]           res_prob,
	output logic [POS_W-1:0]            res_pos,
	output logic                        res_final,
	output logic                        res_ovf
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic [CW-1:0]          count_q;
	logic [VALUE_WIDTH-1:0] max_q;
	logic                   drop_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CW-1:0]          rd_q;
	logic [CW-1:0]          got_q;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   rd_v_q;
	logic                   issue;
	logic                   e_v;
	logic [15:0]            e;
	logic                   div_done;
	logic [DIV_W-1:0]       quo;
	logic [DIV_W-1:0]       recip_q;
	logic                   full;
	logic [AW-1:0]          wr_addr;

	assign full    = (count_q == CW'(DEPTH));
	assign wr_addr = AW'(count_q);

	smx_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (in_xfer && !full),
		.wr_addr (wr_addr),
		.wr_data (in_value),
		.rd_addr (AW'(rd_q)),
		.rd_data (rd_data)
	);

	// Collection: count, maximum and drop flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= MOST_NEG;
			drop_q  <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			max_q   <= MOST_NEG;
			drop_q  <= 1'b0;
		end else if (in_xfer) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
				if ($signed(in_value) > $signed(max_q)) begin
					max_q <= in_value;
				end
			end
		end
	end

	// Read issue: one element per cycle in the sum pass, gated by the output in the
	// normalise pass so that at most one result is in flight.
	logic inflight_q;
	assign issue = (rd_q < count_q) &&
		(cmd.sum_en || (cmd.norm_en && !inflight_q && !out_busy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q       <= '0;
			rd_v_q     <= 1'b0;
			got_q      <= '0;
			inflight_q <= 1'b0;
		end else begin
			rd_v_q <= issue;
			if (cmd.rd_start) begin
				rd_q       <= '0;
				got_q      <= '0;
				inflight_q <= 1'b0;
			end else begin
				if (issue) begin
					rd_q <= rd_q + CW'(1);
				end
				if (e_v) begin
					got_q <= got_q + CW'(1);
				end
				if (cmd.norm_en) begin
					if (issue) begin
						inflight_q <= 1'b1;
					end else if (res_valid && !out_busy) begin
						inflight_q <= 1'b0;
					end
				end
			end
		end
	end

	smx_exp #(.VALUE_WIDTH(VALUE_WIDTH)) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_v_q),
		.x         (rd_data),
		.mx        (max_q),
		.out_valid (e_v),
		.e         (e)
	);

	// Exponent sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.clear) begin
			sum_q <= '0;
		end else if (cmd.sum_en && e_v) begin
			sum_q <= sum_q + SUM_W'(e);
		end
	end

	smx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.den    (sum_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			recip_q <= quo;
		end
	end

	// Normalise: product registered, then round and saturate.
	logic [47:0]        p_s1;
	logic               p_v_s1;
	logic [POS_W-1:0]   pos_s1;
	logic               fin_s1;
	logic [32:0]        rnd;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_v_s1    <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			p_v_s1 <= cmd.norm_en && e_v;
			if (p_v_s1) begin
				res_valid <= 1'b1;
			end else if (!out_busy) begin
				res_valid <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		p_s1   <= 48'(e) * 48'(recip_q[31:0]);
		pos_s1 <= POS_W'(got_q);
		fin_s1 <= (got_q + CW'(1)) == count_q;
	end
	assign rnd = 33'((p_s1 + 48'd32768) >> 16);
	always_ff @(posedge clk) begin
		if (p_v_s1) begin
			res_prob  <= (rnd > 33'd65535) ? 16'hFFFF : rnd[15:0];
			res_pos   <= pos_s1;
			res_final <= fin_s1;
			res_ovf   <= drop_q;
		end
	end

	// Pipeline occupancy of the exponent unit during the sum pass.
	logic u_busy;
	assign u_busy = (got_q != rd_q);

	assign stat.sum_done  = cmd.sum_en && (got_q == count_q) && !rd_v_q && !e_v
		&& (rd_q == count_q) && !u_busy;
	assign stat.div_done  = div_done;
	assign stat.norm_done = cmd.norm_en && (rd_q == count_q) && !inflight_q;

endmodule
`default_nettype wire

### rtl/core/smx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Softmax controller
// Sequences collection, exponent sum, reciprocal and normalise passes.
// ----------------------------------------------------------------------------
module smx_ctrl
	import smx_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_xfer,
	input  wire logic      in_last,
	input  wire smx_stat_t stat,
	output smx_cmd_t       cmd,
	output logic           in_stall
);

	smx_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_COLLECT: if (in_xfer && in_last) state_d = ST_SUM;
			ST_SUM:     if (stat.sum_done) state_d = ST_DIV;
			ST_DIV:     if (stat.div_done) state_d = ST_NORM;
			ST_NORM:    if (stat.norm_done) state_d = ST_CLEAR;
			ST_CLEAR:   state_d = ST_COLLECT;
			default:    state_d = ST_COLLECT;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_COLLECT: begin
				in_stall     = 1'b0;
				cmd.rd_start = 1'b1;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				if (stat.sum_done) begin
					cmd.div_start = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.rd_start = stat.div_done;
			end
			ST_NORM:  cmd.norm_en = 1'b1;
			ST_CLEAR: cmd.clear   = 1'b1;
			default:  cmd         = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/softmax_vector_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Softmax vector engine
// Max-subtracted softmax over a vector of signed Q8.8 logits.
//
//   Channel  Direction  Fields                                   Handshake
//   in       input      value, last                              valid / stall
//   out      output     probability, position, final_res,        valid / stall
//                       overflowed
//
// Elements are taken one per cycle while collecting. After the last element come the
// sum pass, the reciprocal divider, the normalise pass (one result at a time through
// the read, exponent and product stages) and the clear; the next vector is taken only
// once collection resumes. Input stall is high outside collection.
// Reset is asynchronous; the element store itself is not cleared.
// Output stall holds the result register and pauses the normalise pass.
// ----------------------------------------------------------------------------
module softmax_vector_engine
	import smx_pkg::*;
#(
	parameter int unsigned DEPTH       = DEPTH_DEF,
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [VALUE_WIDTH-1:0] value,
	input  wire logic                   last,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [PROB_W-1:0]           probability,
	output logic [POS_W-1:0]            position,
	output logic                        final_res,
	output logic                        overflowed
);

	smx_cmd_t  cmd;
	smx_stat_t stat;
	logic      in_xfer;

	assign in_xfer = in_valid && !in_stall;

	smx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_xfer  (in_xfer),
		.in_last  (last),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	smx_datapath #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_xfer   (in_xfer),
		.in_value  (value),
		.out_busy  (out_stall),
		.res_valid (out_valid),
		.res_prob  (probability),
		.res_pos   (position),
		.res_final (final_res),
		.res_ovf   (overflowed)
	);

	// No input transfer while results are being produced.
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while results pending");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(probability) && $stable(position))
		else $error("stalled result changed");

	// Only one command phase at a time.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sum_en, cmd.norm_en, cmd.clear}))
		else $error("conflicting datapath commands");

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Softmax engine testbench
// Drives vectors of Q8.8 logits through the engine and compares every
// probability transfer with a bit-exact fixed-point softmax worked out here.
// ----------------------------------------------------------------------------
module tb;
	import smx_pkg::*;

	localparam int unsigned VEC_DEPTH = DEPTH_DEF;
	localparam int unsigned IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} element_t;

	typedef struct packed {
		logic [PROB_W-1:0] probability;
		logic [POS_W-1:0]  position;
		logic              final_res;
		logic              overflowed;
	} prob_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] value = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [PROB_W-1:0] probability;
	logic [POS_W-1:0] position;
	logic final_res;
	logic overflowed;

	element_t pending_elems[$];
	prob_t expected_probs[$];
	bit stimulus_done = 1'b0;
	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	bit hold_req = 1'b0;
	int unsigned hold_left = 0;

	// Vector state of the predictor.
	logic signed [15:0] vec_store[VEC_DEPTH];
	int unsigned vec_count = 0;
	logic signed [15:0] vec_max = 16'sh8000;
	bit vec_dropped = 1'b0;

	softmax_vector_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value(value), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.probability(probability), .position(position),
		.final_res(final_res), .overflowed(overflowed)
	);

	always #2 clk = ~clk;

	// exp(x - max) as Q0.16 using the base-2 table and an integer shift.
	function automatic logic [31:0] exp_offset(logic signed [15:0] x, logic signed [15:0] mx);
		logic [63:0] delta;
		logic [63:0] t;
		logic [63:0] acc;
		logic [63:0] whole;
		logic [7:0] f;
		begin
			delta = 64'(32'sd0 + mx - x);
			t = (delta * 64'd23637 + 64'd8192) >> 14;
			whole = t >> 8;
			f = t[7:0];
			acc = 64'd65536;
			for (int b = 7; b >= 0; b--)
				if (f[b]) acc = (acc * 64'(frac_pow(3'(b))) + 64'd32768) >> 16;
			if (whole > 64'd16) return 32'd0;
			acc = acc >> whole;
			if (acc > 64'd65535) acc = 64'd65535;
			return acc[31:0];
		end
	endfunction

	// Accept one element and, on the last one, queue the vector's probabilities.
	task automatic predict_softmax(element_t el);
		logic [63:0] total;
		logic [63:0] recip;
		logic [63:0] p;
		prob_t r;
		begin
			if (vec_count < VEC_DEPTH) begin
				vec_store[vec_count] = el.value;
				if ($signed(el.value) > vec_max) vec_max = el.value;
				vec_count++;
			end else begin
				vec_dropped = 1'b1;
			end
			if (el.last) begin
				total = 0;
				for (int i = 0; i < vec_count; i++)
					total += exp_offset(vec_store[i], vec_max);
				if (total == 0) total = 1;
				recip = (64'd65535 << 16) / total;
				for (int i = 0; i < vec_count; i++) begin
					p = (64'(exp_offset(vec_store[i], vec_max)) * recip + 64'd32768) >> 16;
					if (p > 64'd65535) p = 64'd65535;
					r.probability = p[15:0];
					r.position = POS_W'(i);
					r.final_res = (i + 1 == vec_count);
					r.overflowed = vec_dropped;
					expected_probs.push_back(r);
				end
				vec_count = 0;
				vec_max = 16'sh8000;
				vec_dropped = 1'b0;
			end
		end
	endtask

	task automatic push_vector(int unsigned len, int unsigned mode);
		element_t el;
		begin
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: el.value = 16'($urandom);
					1: el.value = 16'($urandom_range(0, 2047) - 1024);
					default: el.value = 16'($urandom_range(0, 511) - 256);
				endcase
				el.last = (i == len - 1);
				pending_elems.push_back(el);
			end
		end
	endtask

	// Stimulus.
	initial begin
		element_t el;
		// Extremes, a single element, ties, and a far-away element.
		el = '{16'h7fff, 1'b1}; pending_elems.push_back(el);
		el = '{16'h8000, 1'b1}; pending_elems.push_back(el);
		el = '{16'h8000, 1'b0}; pending_elems.push_back(el);
		el = '{16'h7fff, 1'b1}; pending_elems.push_back(el);
		el = '{16'h0100, 1'b0}; pending_elems.push_back(el);
		el = '{16'h0100, 1'b0}; pending_elems.push_back(el);
		el = '{16'h0000, 1'b0}; pending_elems.push_back(el);
		el = '{16'hffff, 1'b1}; pending_elems.push_back(el);
		el = '{16'h5555, 1'b0}; pending_elems.push_back(el);
		el = '{16'haaaa, 1'b1}; pending_elems.push_back(el);
		// Overfull vector: the last element is dropped but still ends the vector.
		push_vector(VEC_DEPTH + 3, 1);
		// Exactly full.
		push_vector(VEC_DEPTH, 2);
		while (pending_elems.size() < 430)
			push_vector($urandom_range(1, 12), $urandom_range(0, 2));
		push_vector(VEC_DEPTH + 1, 0);
		stimulus_done = 1'b1;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: one element per transfer with a random gap before each.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_softmax('{value, last});
				void'(pending_elems.pop_front());
				send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
				if ($urandom_range(0, 1)) send_gap = 0;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_elems.size() > 0) begin
					in_valid <= 1'b1;
					value <= pending_elems[0].value;
					last <= pending_elems[0].last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off once, with the sender still offering.
	initial begin
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_req = 1'b1;
		hold_left = 2000;
		while (hold_left > 0) begin
			@(posedge clk);
			hold_left--;
		end
		hold_req = 1'b0;
	end

	// Receiver: checks each transfer against the oldest expectation.
	always @(posedge clk) begin
		prob_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_probs.size() == 0) begin
					$error("unexpected result at position %0d", position);
					error_count++;
				end else begin
					exp_r = expected_probs.pop_front();
					if (probability !== exp_r.probability) begin
						$error("probability: expected %0d, got %0d", exp_r.probability,
							probability);
						error_count++;
					end
					if (position !== exp_r.position) begin
						$error("position: expected %0d, got %0d", exp_r.position, position);
						error_count++;
					end
					if (final_res !== exp_r.final_res) begin
						$error("final_res: expected %0d, got %0d", exp_r.final_res, final_res);
						error_count++;
					end
					if (overflowed !== exp_r.overflowed) begin
						$error("overflowed: expected %0d, got %0d", exp_r.overflowed,
							overflowed);
						error_count++;
					end
				end
				recv_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
			end
			if (hold_req) begin
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog and end of run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done && pending_elems.size() == 0 && !in_valid);
		wait (expected_probs.size() == 0);
		repeat (400) @(posedge clk);
		if (error_count == 0 && expected_probs.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
rtl/core/smx_pkg.sv
rtl/core/smx_ram.sv
rtl/core/smx_exp.sv
rtl/core/smx_div.sv
rtl/core/smx_datapath.sv
rtl/core/smx_ctrl.sv
rtl/core/softmax_vector_engine.sv
bench/tb.sv
